// File: rtl/core/xs32_pkg.sv
package xs32_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned DivW   = 31;
  localparam int unsigned SpanW  = 33;
  localparam int unsigned CntW   = 5;
  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_RANGE  = 2'd1,
    MODE_COIN   = 2'd2,
    MODE_CHANCE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } fsm_t;

  function automatic logic [WordW-1:0] xs_advance(input logic [WordW-1:0] x);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

// File: rtl/core/xorshift32_random_generator_top.sv
// xorshift32 generator with raw, range, coin and chance requests
// out_tvalid rises once the divider steps in ST_DIV are done and the state moves to ST_DONE
// a new item is accepted only in ST_IDLE, after the previous result is taken with out_tready
// the remainder comes from a restoring divider, one bit per cycle, word bit 31 down to bit 0
// reset: synchronous active-low; generator state clears to zero, so words stay zero until seeded
module xorshift32_random_generator_top
  import xs32_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // low_bound[31:0], high_bound[63:32], chance_divisor[94:64], pad
  input  logic [1:0]   in_tuser,   // mode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata   // value[31:0], hit[32], error[33], pad
);

  fsm_t              state_r, state_nxt;
  logic [WordW-1:0]  gen_r, gen_nxt;
  logic [WordW-1:0]  word_r, word_nxt;
  logic [WordW-1:0]  rem_r, rem_nxt;
  logic [SpanW-1:0]  dvs_r, dvs_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  mode_t             mode_r, mode_nxt;
  logic [WordW-1:0]  lo_r, lo_nxt;
  logic              err_r, err_nxt;
  logic [WordW-1:0]  value_r, value_nxt;
  logic              hit_r, hit_nxt;
  logic              error_r, error_nxt;

  logic              in_fire;
  logic              out_fire;
  logic              div_step;
  logic              last_step;
  logic [WordW-1:0]  lo_in, hi_in;
  logic [DivW-1:0]   cdiv_in;
  mode_t             mode_in;
  logic [SpanW:0]    span_full;
  logic [SpanW-1:0]  trial;
  logic [SpanW-1:0]  trial_sub;
  logic              trial_ge;
  logic [WordW-1:0]  rem_final;

  assign lo_in   = in_tdata[31:0];
  assign hi_in   = in_tdata[63:32];
  assign cdiv_in = in_tdata[94:64];
  assign mode_in = mode_t'(in_tuser);

  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;
  assign last_step = (cnt_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (last_step) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    div_step   = 1'b0;
    case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_DIV:  div_step   = 1'b1;
      ST_DONE: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = {6'd0, error_r, hit_r, value_r};

  // shared restoring divider step
  assign trial     = {rem_r, word_r[cnt_r]};
  assign trial_ge  = (trial >= dvs_r);
  assign trial_sub = trial - dvs_r;
  assign rem_final = trial_ge ? trial_sub[WordW-1:0] : trial[WordW-1:0];

  assign span_full = {{2{hi_in[WordW-1]}}, hi_in} - {{2{lo_in[WordW-1]}}, lo_in}
                     + {{SpanW{1'b0}}, 1'b1};

  always_comb begin
    gen_nxt   = gen_r;
    word_nxt  = word_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    lo_nxt    = lo_r;
    err_nxt   = err_r;
    value_nxt = value_r;
    hit_nxt   = hit_r;
    error_nxt = error_r;

    if (cfg_wen) gen_nxt = cfg_wdata;

    if (in_fire) begin
      gen_nxt  = xs_advance(gen_r);
      word_nxt = xs_advance(gen_r);
      rem_nxt  = '0;
      cnt_nxt  = CntW'(WordW - 1);
      mode_nxt = mode_in;
      lo_nxt   = lo_in;
      if (mode_in == MODE_RANGE) begin
        dvs_nxt = span_full[SpanW-1:0];
        err_nxt = ($signed(hi_in) < $signed(lo_in));
      end else begin
        dvs_nxt = {2'b00, cdiv_in};
        err_nxt = (mode_in == MODE_CHANCE) && (cdiv_in == '0);
      end
    end

    if (div_step) begin
      rem_nxt = rem_final;
      cnt_nxt = cnt_r - CntW'(1);
      if (last_step) begin
        value_nxt = '0;
        hit_nxt   = 1'b0;
        error_nxt = err_r;
        case (mode_r)
          MODE_RAW:    value_nxt = word_r;
          MODE_RANGE:  value_nxt = err_r ? lo_r : (lo_r + rem_final);
          MODE_COIN:   hit_nxt   = word_r[0];
          MODE_CHANCE: hit_nxt   = ~err_r && (rem_final == '0);
          default:     value_nxt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gen_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    cnt_r   <= cnt_nxt;
    mode_r  <= mode_nxt;
    lo_r    <= lo_nxt;
    err_r   <= err_nxt;
    value_r <= value_nxt;
    hit_r   <= hit_nxt;
    error_r <= error_nxt;
  end

endmodule
